// ----- rtl/vpa_pkg.sv -----
// Shared types, constants and helper functions of the variable partition allocator.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package vpa_pkg;

    localparam int ADDR_BITS = 20;
    localparam int MAX_HOLES = 16;
    localparam int MAX_PROCS = 16;

    localparam int LEN_W      = ADDR_BITS + 1;
    localparam int HIDX_W     = $clog2(MAX_HOLES);
    localparam int PIDX_W     = $clog2(MAX_PROCS);
    localparam int PID_W      = 16;
    localparam int SIZE_W     = 21;
    localparam int OFF_W      = 20;
    localparam int OUT_ADDR_W = 20;
    localparam int CFG_W      = 21;
    localparam int CFG_IDX_W  = 1;
    // Wide enough for any size, length, or end-of-region sum.
    localparam int WIDE_W     = ((SIZE_W > LEN_W) ? SIZE_W : LEN_W) + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     MEMORY_SIZE_RST = CFG_W'(1048576);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_XLATE   = 2'd2,
        OP_COMPACT = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NO_FIT = 3'd1,
        ST_NO_PID = 3'd2,
        ST_BOUND  = 3'd3,
        ST_FULL   = 3'd4,
        ST_DUP    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        SM_FIT = 2'd0,   // hole fit search (first or best)
        SM_ADJ = 2'd1,   // neighbor search for a released region
        SM_LOW = 2'd2    // lowest base among remaining owners
    } t_scan_mode;

    typedef struct packed {
        t_opcode             opcode;
        logic [PID_W-1:0]    pid;
        logic [SIZE_W-1:0]   request_size;
        logic [OFF_W-1:0]    offset;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]            status;
        logic [OUT_ADDR_W-1:0] address;
    } t_out_beat;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     len;
    } t_cand;

    typedef struct packed {
        logic take;
        logic prev;
        logic next;
    } t_scan_flags;

    // Usable bytes: memory size saturated at the address span.
    function automatic logic [LEN_W-1:0] usable_size(input logic [CFG_W-1:0] ms);
        logic [32:0] m33;
        logic [32:0] cap33;
        m33   = 33'(ms);
        cap33 = 33'(1) << ADDR_BITS;
        return LEN_W'((m33 > cap33) ? cap33 : m33);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/vpa_scan_unit.sv -----
// Shared compare unit of the allocator: judges one table entry against the running pick or a freed region.
// Depends on vpa_pkg.
`default_nettype none
module vpa_scan_unit (
    input  vpa_pkg::t_scan_mode             i_mode,
    input  logic                            i_policy,
    input  vpa_pkg::t_cand                  i_cand,
    input  logic                            i_best_hit,
    input  logic [vpa_pkg::ADDR_BITS-1:0]   i_best_start,
    input  logic [vpa_pkg::LEN_W-1:0]       i_best_len,
    input  logic [vpa_pkg::WIDE_W-1:0]      i_key_a,
    input  logic [vpa_pkg::WIDE_W-1:0]      i_key_b,
    output vpa_pkg::t_scan_flags            o_flags
);

    logic [vpa_pkg::WIDE_W-1:0] w_start;
    logic [vpa_pkg::WIDE_W-1:0] w_len;
    logic [vpa_pkg::WIDE_W-1:0] w_end;
    logic                       w_lower;
    logic                       w_smaller;
    logic                       w_fit;
    logic                       w_prev;

    assign w_start   = vpa_pkg::WIDE_W'(i_cand.start);
    assign w_len     = vpa_pkg::WIDE_W'(i_cand.len);
    assign w_end     = w_start + w_len;
    assign w_lower   = i_cand.start < i_best_start;
    assign w_smaller = (i_cand.len < i_best_len)
                    || ((i_cand.len == i_best_len) && w_lower);
    assign w_fit     = i_cand.valid && (w_len >= i_key_a);
    assign w_prev    = i_cand.valid && (w_end == i_key_a);

    always_comb begin
        o_flags = '0;
        case (i_mode)
            vpa_pkg::SM_FIT: begin
                o_flags.take = w_fit && (!i_best_hit || (i_policy ? w_smaller : w_lower));
            end
            vpa_pkg::SM_ADJ: begin
                o_flags.prev = w_prev;
                o_flags.next = i_cand.valid && !w_prev && (w_start == (i_key_a + i_key_b));
            end
            vpa_pkg::SM_LOW: begin
                o_flags.take = i_cand.valid && (!i_best_hit || w_lower);
            end
            default: begin
                o_flags = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/variable_partition_allocator_core.sv -----
// Top level of the variable partition allocator: hole and owner tables, sequencer, I/O.
// Depends on vpa_pkg and vpa_scan_unit.
// Throughput: one request at a time, paced by 16-entry scans: an owner scan, then
// a hole scan through the shared compare unit for allocate/free; compact runs an
// owner scan through the unit per placed owner, plus a final one that finds none.
// Reset: one hole spans 1048576 bytes, no owners, first fit; no clearing pass.
`default_nettype none
module variable_partition_allocator_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output      logic                             o_in_ready,
    input  wire vpa_pkg::t_in_beat                i_in_data,
    output      logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    output      vpa_pkg::t_out_beat               o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [vpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [vpa_pkg::CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_OSCAN = 9'b000000010,
        S_ODEC  = 9'b000000100,
        S_HSCAN = 9'b000001000,
        S_APPLY = 9'b000010000,
        S_MERGE = 9'b000100000,
        S_CPICK = 9'b001000000,
        S_CMOVE = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // Hole table: entry valid bits in flops, reset leaves only entry 0 valid at once.
    logic [vpa_pkg::ADDR_BITS-1:0] r_hstart [vpa_pkg::MAX_HOLES];
    logic [vpa_pkg::LEN_W-1:0]     r_hlen   [vpa_pkg::MAX_HOLES];
    logic [vpa_pkg::MAX_HOLES-1:0] r_hvalid;
    // Owner table: data undefined until written.
    logic [vpa_pkg::PID_W-1:0]     r_opid   [vpa_pkg::MAX_PROCS];
    logic [vpa_pkg::ADDR_BITS-1:0] r_obase  [vpa_pkg::MAX_PROCS];
    logic [vpa_pkg::LEN_W-1:0]     r_olen   [vpa_pkg::MAX_PROCS];
    logic [vpa_pkg::MAX_PROCS-1:0] r_ovalid;

    logic                          r_policy;
    logic [vpa_pkg::CFG_W-1:0]     r_msize;

    t_state                        r_state;
    logic [vpa_pkg::HIDX_W-1:0]    r_hidx;
    logic [vpa_pkg::PIDX_W-1:0]    r_pidx;

    // Latched request.
    vpa_pkg::t_opcode              r_op;
    logic [vpa_pkg::PID_W-1:0]     r_pid;
    logic [vpa_pkg::SIZE_W-1:0]    r_req;
    logic [vpa_pkg::OFF_W-1:0]     r_off;

    // Owner scan results (also the compact pick).
    logic                          r_o_hit;
    logic [vpa_pkg::PIDX_W-1:0]    r_o_idx;
    logic [vpa_pkg::ADDR_BITS-1:0] r_o_base;
    logic [vpa_pkg::LEN_W-1:0]     r_o_len;
    logic                          r_f_hit;
    logic [vpa_pkg::PIDX_W-1:0]    r_f_idx;

    // Hole scan results: chosen hole on allocate, preceding neighbor on free.
    logic                          r_b_hit;
    logic [vpa_pkg::HIDX_W-1:0]    r_b_idx;
    logic [vpa_pkg::ADDR_BITS-1:0] r_b_start;
    logic [vpa_pkg::LEN_W-1:0]     r_b_len;
    logic                          r_n_hit;
    logic [vpa_pkg::HIDX_W-1:0]    r_n_idx;
    logic [vpa_pkg::LEN_W-1:0]     r_n_len;
    logic                          r_e_hit;
    logic [vpa_pkg::HIDX_W-1:0]    r_e_idx;

    logic [vpa_pkg::MAX_PROCS-1:0] r_done;
    logic [vpa_pkg::LEN_W-1:0]     r_packed;

    vpa_pkg::t_status              r_status;
    logic [vpa_pkg::OUT_ADDR_W-1:0] r_addr;
    logic                          r_out_valid;
    vpa_pkg::t_out_beat            r_out;

    logic                          w_in_fire;
    logic                          w_h_last;
    logic                          w_p_last;
    logic [vpa_pkg::LEN_W-1:0]     w_usable;
    logic [vpa_pkg::LEN_W-1:0]     w_cfg_usable;
    logic [vpa_pkg::WIDE_W-1:0]    w_req_w;
    vpa_pkg::t_scan_mode           w_mode;
    vpa_pkg::t_cand                w_cand;
    logic [vpa_pkg::WIDE_W-1:0]    w_key_a;
    vpa_pkg::t_scan_flags          w_flags;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;
    assign w_h_last     = (r_hidx == vpa_pkg::HIDX_W'(vpa_pkg::MAX_HOLES - 1));
    assign w_p_last     = (r_pidx == vpa_pkg::PIDX_W'(vpa_pkg::MAX_PROCS - 1));
    assign w_usable     = vpa_pkg::usable_size(r_msize);
    assign w_cfg_usable = vpa_pkg::usable_size(i_cfg_data);
    assign w_req_w      = vpa_pkg::WIDE_W'(r_req);

    // Feed the shared compare unit: holes during the hole scan, owners during compact.
    always_comb begin
        if (r_state == S_CPICK) begin
            w_mode       = vpa_pkg::SM_LOW;
            w_cand.valid = r_ovalid[r_pidx] && !r_done[r_pidx];
            w_cand.start = r_obase[r_pidx];
            w_cand.len   = r_olen[r_pidx];
        end else begin
            w_mode       = (r_op == vpa_pkg::OP_ALLOC) ? vpa_pkg::SM_FIT : vpa_pkg::SM_ADJ;
            w_cand.valid = r_hvalid[r_hidx];
            w_cand.start = r_hstart[r_hidx];
            w_cand.len   = r_hlen[r_hidx];
        end
        w_key_a = (r_op == vpa_pkg::OP_ALLOC) ? w_req_w : vpa_pkg::WIDE_W'(r_o_base);
    end

    vpa_scan_unit u_scan (
        .i_mode       (w_mode),
        .i_policy     (r_policy),
        .i_cand       (w_cand),
        .i_best_hit   ((r_state == S_CPICK) ? r_o_hit : r_b_hit),
        .i_best_start ((r_state == S_CPICK) ? r_o_base : r_b_start),
        .i_best_len   (r_b_len),
        .i_key_a      (w_key_a),
        .i_key_b      (vpa_pkg::WIDE_W'(r_o_len)),
        .o_flags      (w_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= 1'b0;
            r_msize     <= vpa_pkg::MEMORY_SIZE_RST;
            r_hvalid    <= vpa_pkg::MAX_HOLES'(1);
            r_hstart[0] <= '0;
            r_hlen[0]   <= vpa_pkg::usable_size(vpa_pkg::MEMORY_SIZE_RST);
            r_ovalid    <= '0;
            r_out_valid <= 1'b0;
            r_hidx      <= '0;
            r_pidx      <= '0;
        end else begin
            // Drop the result beat once taken, unless a new one replaces it.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            // Configuration writes must arrive only while idle; the block itself does not enforce it.
            if (i_cfg_we) begin
                if (i_cfg_idx == vpa_pkg::CFG_FIT_POLICY) begin
                    r_policy <= i_cfg_data[0];
                end else if (i_cfg_idx == vpa_pkg::CFG_MEMORY_SIZE) begin
                    // Re-initialize: no owners, one hole over the usable size if that is nonzero.
                    r_msize     <= i_cfg_data;
                    r_ovalid    <= '0;
                    r_hvalid    <= vpa_pkg::MAX_HOLES'(w_cfg_usable != '0);
                    r_hstart[0] <= '0;
                    r_hlen[0]   <= w_cfg_usable;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_op     <= i_in_data.opcode;
                        r_pid    <= i_in_data.pid;
                        r_req    <= i_in_data.request_size;
                        r_off    <= i_in_data.offset;
                        r_hidx   <= '0;
                        r_pidx   <= '0;
                        r_o_hit  <= 1'b0;
                        r_f_hit  <= 1'b0;
                        r_b_hit  <= 1'b0;
                        r_n_hit  <= 1'b0;
                        r_e_hit  <= 1'b0;
                        r_done   <= '0;
                        r_packed <= '0;
                        r_addr   <= '0;
                        if (i_in_data.opcode == vpa_pkg::OP_COMPACT) begin
                            r_status <= vpa_pkg::ST_OK;
                            r_state  <= S_CPICK;
                        end else if ((i_in_data.opcode == vpa_pkg::OP_ALLOC)
                                     && (i_in_data.request_size == '0)) begin
                            r_status <= vpa_pkg::ST_NO_FIT;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= vpa_pkg::ST_OK;
                            r_state  <= S_OSCAN;
                        end
                    end
                end

                S_OSCAN: begin
                    // Look up the pid and the first free owner slot.
                    if (r_ovalid[r_pidx] && (r_opid[r_pidx] == r_pid)) begin
                        r_o_hit  <= 1'b1;
                        r_o_idx  <= r_pidx;
                        r_o_base <= r_obase[r_pidx];
                        r_o_len  <= r_olen[r_pidx];
                    end
                    if (!r_ovalid[r_pidx] && !r_f_hit) begin
                        r_f_hit <= 1'b1;
                        r_f_idx <= r_pidx;
                    end
                    r_pidx <= r_pidx + 1'b1;
                    if (w_p_last) begin
                        r_state <= S_ODEC;
                    end
                end

                S_ODEC: begin
                    case (r_op)
                        vpa_pkg::OP_ALLOC: begin
                            if (r_o_hit) begin
                                r_status <= vpa_pkg::ST_DUP;
                                r_state  <= S_DONE;
                            end else if (!r_f_hit) begin
                                r_status <= vpa_pkg::ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_HSCAN;
                            end
                        end
                        vpa_pkg::OP_FREE: begin
                            if (!r_o_hit) begin
                                r_status <= vpa_pkg::ST_NO_PID;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_HSCAN;
                            end
                        end
                        vpa_pkg::OP_XLATE: begin
                            r_state <= S_DONE;
                            if (!r_o_hit) begin
                                r_status <= vpa_pkg::ST_NO_PID;
                            end else if (vpa_pkg::WIDE_W'(r_off)
                                         >= vpa_pkg::WIDE_W'(r_o_len)) begin
                                r_status <= vpa_pkg::ST_BOUND;
                            end else begin
                                r_addr <= vpa_pkg::OUT_ADDR_W'(vpa_pkg::WIDE_W'(r_o_base)
                                          + vpa_pkg::WIDE_W'(r_off));
                            end
                        end
                        default: begin
                            r_status <= vpa_pkg::ST_OK;
                            r_state  <= S_DONE;
                        end
                    endcase
                end

                S_HSCAN: begin
                    if (r_op == vpa_pkg::OP_ALLOC) begin
                        if (w_flags.take) begin
                            r_b_hit   <= 1'b1;
                            r_b_idx   <= r_hidx;
                            r_b_start <= w_cand.start;
                            r_b_len   <= w_cand.len;
                        end
                    end else begin
                        if (w_flags.prev) begin
                            r_b_hit   <= 1'b1;
                            r_b_idx   <= r_hidx;
                            r_b_start <= w_cand.start;
                            r_b_len   <= w_cand.len;
                        end
                        if (w_flags.next) begin
                            r_n_hit <= 1'b1;
                            r_n_idx <= r_hidx;
                            r_n_len <= w_cand.len;
                        end
                        if (!r_hvalid[r_hidx] && !r_e_hit) begin
                            r_e_hit <= 1'b1;
                            r_e_idx <= r_hidx;
                        end
                    end
                    r_hidx <= r_hidx + 1'b1;
                    if (w_h_last) begin
                        r_state <= S_APPLY;
                    end
                end

                S_APPLY: begin
                    if (r_op == vpa_pkg::OP_ALLOC) begin
                        r_state <= S_DONE;
                        if (!r_b_hit) begin
                            r_status <= vpa_pkg::ST_NO_FIT;
                        end else begin
                            // Carve the grant from the front of the chosen hole.
                            r_hstart[r_b_idx] <= vpa_pkg::ADDR_BITS'(
                                                 vpa_pkg::WIDE_W'(r_b_start) + w_req_w);
                            r_hlen[r_b_idx]   <= vpa_pkg::LEN_W'(
                                                 vpa_pkg::WIDE_W'(r_b_len) - w_req_w);
                            r_hvalid[r_b_idx] <= (vpa_pkg::WIDE_W'(r_b_len) != w_req_w);
                            r_ovalid[r_f_idx] <= 1'b1;
                            r_opid[r_f_idx]   <= r_pid;
                            r_obase[r_f_idx]  <= r_b_start;
                            r_olen[r_f_idx]   <= vpa_pkg::LEN_W'(r_req);
                            r_addr            <= vpa_pkg::OUT_ADDR_W'(r_b_start);
                        end
                    end else begin
                        if (r_b_hit && r_n_hit) begin
                            r_hlen[r_b_idx]   <= r_b_len + r_o_len + r_n_len;
                            r_ovalid[r_o_idx] <= 1'b0;
                            r_state           <= S_MERGE;
                        end else if (r_b_hit) begin
                            r_hlen[r_b_idx]   <= r_b_len + r_o_len;
                            r_ovalid[r_o_idx] <= 1'b0;
                            r_state           <= S_DONE;
                        end else if (r_n_hit) begin
                            r_hstart[r_n_idx] <= r_o_base;
                            r_hlen[r_n_idx]   <= r_n_len + r_o_len;
                            r_ovalid[r_o_idx] <= 1'b0;
                            r_state           <= S_DONE;
                        end else if (r_e_hit) begin
                            r_hvalid[r_e_idx] <= 1'b1;
                            r_hstart[r_e_idx] <= r_o_base;
                            r_hlen[r_e_idx]   <= r_o_len;
                            r_ovalid[r_o_idx] <= 1'b0;
                            r_state           <= S_DONE;
                        end else begin
                            // Isolated region and no hole slot: keep the allocation.
                            r_status <= vpa_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end
                    end
                end

                S_MERGE: begin
                    // The following hole was absorbed into the preceding one.
                    r_hvalid[r_n_idx] <= 1'b0;
                    r_state           <= S_DONE;
                end

                S_CPICK: begin
                    // Find the lowest-based owner not yet moved.
                    if (w_flags.take) begin
                        r_o_hit  <= 1'b1;
                        r_o_idx  <= r_pidx;
                        r_o_base <= w_cand.start;
                        r_o_len  <= w_cand.len;
                    end
                    r_pidx <= r_pidx + 1'b1;
                    if (w_p_last) begin
                        r_state <= S_CMOVE;
                    end
                end

                S_CMOVE: begin
                    if (r_o_hit) begin
                        r_obase[r_o_idx] <= vpa_pkg::ADDR_BITS'(r_packed);
                        r_done[r_o_idx]  <= 1'b1;
                        r_packed         <= r_packed + r_o_len;
                        r_o_hit          <= 1'b0;
                        r_pidx           <= '0;
                        r_state          <= S_CPICK;
                    end else begin
                        // All owners packed: leave one hole at the top if any space remains.
                        r_hvalid <= vpa_pkg::MAX_HOLES'(r_packed < w_usable);
                        r_hstart[0] <= vpa_pkg::ADDR_BITS'(r_packed);
                        r_hlen[0]   <= w_usable - r_packed;
                        r_state     <= S_DONE;
                    end
                end

                S_DONE: begin
                    // Hold until the output register is free.
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out.status   <= r_status;
                        r_out.address  <= r_addr;
                        r_state        <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A zero-size allocate goes straight to a no-fit answer.
    a_zero_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_in_data.opcode == vpa_pkg::OP_ALLOC)
         && (i_in_data.request_size == '0))
        |=> (r_state == S_DONE) && (r_status == vpa_pkg::ST_NO_FIT))
        else $error("zero-size allocate not rejected");

    // The chosen hole must really hold the request.
    a_fit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_APPLY) && (r_op == vpa_pkg::OP_ALLOC) && r_b_hit)
        |-> (vpa_pkg::WIDE_W'(r_b_len) >= w_req_w))
        else $error("selected hole smaller than request");

    // Neighbors of a released region are two different holes.
    a_merge_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_APPLY) && (r_op == vpa_pkg::OP_FREE) && r_b_hit && r_n_hit)
        |-> (r_b_idx != r_n_idx))
        else $error("preceding and following hole coincide");

    // Compact never moves the same owner twice.
    a_pack_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMOVE) && r_o_hit) |-> !r_done[r_o_idx])
        else $error("owner packed twice");

endmodule
`default_nettype wire

// ----- dv/tb_variable_partition_allocator_core.sv -----
// Self-checking testbench of the variable partition allocator: random and directed
// requests, a software model of the hole and owner tables, and a result scoreboard.
// Depends on vpa_pkg and variable_partition_allocator_core.
`default_nettype none

class alloc_scoreboard;
    vpa_pkg::t_out_beat pending_q[$];
    int mismatches;
    int checked;

    // Hold an expected result for a request just accepted.
    function void note_request(vpa_pkg::t_out_beat exp_beat);
        pending_q.insert(pending_q.size(), exp_beat);
    endfunction

    // Compare one result beat with the oldest expected result.
    function void check_result(vpa_pkg::t_out_beat got);
        vpa_pkg::t_out_beat exp_beat;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status=%0d address=%0h",
                         got.status, got.address);
            return;
        end
        exp_beat = pending_q.pop_front();
        checked++;
        if (got.status !== exp_beat.status || got.address !== exp_beat.address) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: expected status=%0d address=%0h, got status=%0d address=%0h",
                         checked, exp_beat.status, exp_beat.address, got.status, got.address);
        end
    endfunction
endclass

module tb_variable_partition_allocator_core;

    localparam int NH = vpa_pkg::MAX_HOLES;
    localparam int NP = vpa_pkg::MAX_PROCS;
    localparam longint CYCLE_LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    vpa_pkg::t_in_beat i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    vpa_pkg::t_out_beat o_out_data;
    logic i_cfg_we = 1'b0;
    logic [vpa_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [vpa_pkg::CFG_W-1:0] i_cfg_data = '0;

    variable_partition_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the allocator tables; wide integers avoid overflow on sums.
    longint hole_base[NH];
    longint hole_len[NH];
    bit     hole_used[NH];
    logic [vpa_pkg::PID_W-1:0] proc_pid[NP];
    longint proc_base[NP];
    longint proc_len[NP];
    bit     proc_used[NP];
    bit     best_fit;
    longint mem_bytes;

    alloc_scoreboard sb = new();

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 1'b0;
    longint cycles = 0;
    int sent = 0;

    function automatic longint usable_bytes();
        return (mem_bytes > (64'd1 << vpa_pkg::ADDR_BITS)) ?
               (64'd1 << vpa_pkg::ADDR_BITS) : mem_bytes;
    endfunction

    function automatic void clear_tables();
        for (int i = 0; i < NH; i++) begin
            hole_base[i] = 0; hole_len[i] = 0; hole_used[i] = 0;
        end
        for (int i = 0; i < NP; i++) begin
            proc_pid[i] = '0; proc_base[i] = 0; proc_len[i] = 0; proc_used[i] = 0;
        end
        hole_len[0] = usable_bytes();
        hole_used[0] = hole_len[0] != 0;
    endfunction

    function automatic int owner_of(logic [vpa_pkg::PID_W-1:0] pid);
        for (int i = 0; i < NP; i++)
            if (proc_used[i] && proc_pid[i] == pid) return i;
        return -1;
    endfunction

    function automatic vpa_pkg::t_status grant(logic [vpa_pkg::PID_W-1:0] pid, longint req,
                                               output longint base);
        int slot, pick;
        slot = -1;
        pick = -1;
        base = 0;
        if (req == 0) return vpa_pkg::ST_NO_FIT;
        if (owner_of(pid) >= 0) return vpa_pkg::ST_DUP;
        for (int i = 0; i < NP; i++)
            if (!proc_used[i] && slot < 0) slot = i;
        if (slot < 0) return vpa_pkg::ST_FULL;
        for (int i = 0; i < NH; i++) begin
            if (!hole_used[i] || hole_len[i] < req) continue;
            if (pick < 0) pick = i;
            else if (!best_fit) begin
                if (hole_base[i] < hole_base[pick]) pick = i;
            end else if (hole_len[i] < hole_len[pick] ||
                         (hole_len[i] == hole_len[pick] && hole_base[i] < hole_base[pick]))
                pick = i;
        end
        if (pick < 0) return vpa_pkg::ST_NO_FIT;
        base = hole_base[pick];
        hole_base[pick] += req;
        hole_len[pick] -= req;
        if (hole_len[pick] == 0) hole_used[pick] = 0;
        proc_used[slot] = 1;
        proc_pid[slot] = pid;
        proc_base[slot] = base;
        proc_len[slot] = req;
        return vpa_pkg::ST_OK;
    endfunction

    function automatic vpa_pkg::t_status release_region(logic [vpa_pkg::PID_W-1:0] pid);
        int o, prv, nxt, slot;
        longint b, l;
        o = owner_of(pid);
        prv = -1;
        nxt = -1;
        slot = -1;
        if (o < 0) return vpa_pkg::ST_NO_PID;
        b = proc_base[o];
        l = proc_len[o];
        for (int i = 0; i < NH; i++) begin
            if (!hole_used[i]) continue;
            if (hole_base[i] + hole_len[i] == b) prv = i;
            else if (hole_base[i] == b + l) nxt = i;
        end
        if (prv >= 0 && nxt >= 0) begin
            hole_len[prv] += l + hole_len[nxt];
            hole_used[nxt] = 0; hole_base[nxt] = 0; hole_len[nxt] = 0;
        end else if (prv >= 0) begin
            hole_len[prv] += l;
        end else if (nxt >= 0) begin
            hole_base[nxt] = b;
            hole_len[nxt] += l;
        end else begin
            for (int i = 0; i < NH; i++)
                if (!hole_used[i] && slot < 0) slot = i;
            if (slot < 0) return vpa_pkg::ST_FULL;
            hole_used[slot] = 1; hole_base[slot] = b; hole_len[slot] = l;
        end
        proc_used[o] = 0;
        return vpa_pkg::ST_OK;
    endfunction

    function automatic void pack_owners();
        bit placed[NP];
        longint packed_end;
        int pick;
        packed_end = 0;
        for (int i = 0; i < NP; i++) placed[i] = 0;
        for (int r = 0; r < NP; r++) begin
            pick = -1;
            for (int i = 0; i < NP; i++)
                if (proc_used[i] && !placed[i] &&
                    (pick < 0 || proc_base[i] < proc_base[pick])) pick = i;
            if (pick < 0) break;
            placed[pick] = 1;
            proc_base[pick] = packed_end;
            packed_end += proc_len[pick];
        end
        for (int i = 0; i < NH; i++) begin
            hole_base[i] = 0; hole_len[i] = 0; hole_used[i] = 0;
        end
        if (packed_end < usable_bytes()) begin
            hole_base[0] = packed_end;
            hole_len[0] = usable_bytes() - packed_end;
            hole_used[0] = 1;
        end
    endfunction

    // Work out the expected result of one request and advance the mirror.
    function automatic vpa_pkg::t_out_beat predict_result(vpa_pkg::t_in_beat req);
        vpa_pkg::t_out_beat r;
        longint a;
        int o;
        vpa_pkg::t_status st;
        a = 0;
        st = vpa_pkg::ST_OK;
        case (req.opcode)
            vpa_pkg::OP_ALLOC: begin
                st = grant(req.pid, longint'(req.request_size), a);
                if (st != vpa_pkg::ST_OK) a = 0;
            end
            vpa_pkg::OP_FREE: st = release_region(req.pid);
            vpa_pkg::OP_XLATE: begin
                o = owner_of(req.pid);
                if (o < 0) st = vpa_pkg::ST_NO_PID;
                else if (longint'(req.offset) >= proc_len[o]) st = vpa_pkg::ST_BOUND;
                else a = proc_base[o] + longint'(req.offset);
            end
            default: pack_owners();
        endcase
        r.status = st;
        r.address = a[vpa_pkg::OUT_ADDR_W-1:0];
        return r;
    endfunction

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Check every result beat at the rising edge.
    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);

    // Receiver: stall at random, or hold off entirely during a pressure window.
    always @(negedge i_clk)
        i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

    task automatic cfg_write(logic [vpa_pkg::CFG_IDX_W-1:0] idx,
                             logic [vpa_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == vpa_pkg::CFG_FIT_POLICY) best_fit = val[0];
        else begin
            mem_bytes = longint'(val);
            clear_tables();
        end
    endtask

    // Offer one request beat and hold it until accepted; valid stays up for a
    // following beat and drops only when the sender idles or drains.
    task automatic send_request(vpa_pkg::t_in_beat req);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(predict_result(req));
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        // idle gap before the next phase
        repeat (300) @(negedge i_clk);
    endtask

    function automatic vpa_pkg::t_in_beat make_req(vpa_pkg::t_opcode op,
                                                   logic [vpa_pkg::PID_W-1:0] pid,
                                                   logic [vpa_pkg::SIZE_W-1:0] sz,
                                                   logic [vpa_pkg::OFF_W-1:0] off);
        vpa_pkg::t_in_beat b;
        b.opcode = op; b.pid = pid; b.request_size = sz; b.offset = off;
        return b;
    endfunction

    // Pick a pid: mostly from a small pool so frees and translates hit live owners.
    function automatic logic [vpa_pkg::PID_W-1:0] pick_pid();
        if ($urandom_range(9) == 0) return vpa_pkg::PID_W'($urandom);
        return vpa_pkg::PID_W'($urandom_range(23)) ^ ($urandom_range(1) ? 16'hFFE0 : 16'h0);
    endfunction

    function automatic vpa_pkg::t_in_beat random_request();
        int o;
        logic [vpa_pkg::SIZE_W-1:0] sz;
        logic [vpa_pkg::OFF_W-1:0] off;
        int k;
        k = $urandom_range(99);
        case ($urandom_range(3))
            0: sz = vpa_pkg::SIZE_W'($urandom_range(1, 64));
            1: sz = vpa_pkg::SIZE_W'($urandom_range(1, 4096));
            2: sz = vpa_pkg::SIZE_W'($urandom_range(1, 1 << 17));
            default: sz = vpa_pkg::SIZE_W'($urandom);
        endcase
        if (k < 3) sz = '0;
        off = vpa_pkg::OFF_W'($urandom);
        o = $urandom_range(NP - 1);
        if (k < 40) return make_req(vpa_pkg::OP_ALLOC, pick_pid(), sz, off);
        if (k < 70) return make_req(vpa_pkg::OP_FREE, proc_used[o] ? proc_pid[o] : pick_pid(),
                                    sz, off);
        if (k < 95) begin
            if (proc_used[o]) begin
                if ($urandom_range(3) != 0)
                    off = vpa_pkg::OFF_W'($urandom_range(0, int'(proc_len[o] - 1)));
                else if ($urandom_range(1)) off = vpa_pkg::OFF_W'(proc_len[o]);
                return make_req(vpa_pkg::OP_XLATE, proc_pid[o], sz, off);
            end
            return make_req(vpa_pkg::OP_XLATE, pick_pid(), sz, off);
        end
        return make_req(vpa_pkg::OP_COMPACT, vpa_pkg::PID_W'($urandom),
                        vpa_pkg::SIZE_W'($urandom), vpa_pkg::OFF_W'($urandom));
    endfunction

    // Fragment memory: many small grants, then free every other one so that
    // frees cannot merge and each freed region opens a new hole.
    task automatic fragment_phase();
        for (int i = 0; i < NP; i++)
            send_request(make_req(vpa_pkg::OP_ALLOC, vpa_pkg::PID_W'(16'h100 + i),
                                  vpa_pkg::SIZE_W'(8), '0));
        for (int i = 0; i < NP; i += 2)
            send_request(make_req(vpa_pkg::OP_FREE, vpa_pkg::PID_W'(16'h100 + i), '0, '0));
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'h200, vpa_pkg::SIZE_W'(4), '0));
        send_request(make_req(vpa_pkg::OP_FREE, 16'h10F, '0, '0));
        send_request(make_req(vpa_pkg::OP_XLATE, 16'h101, '0, vpa_pkg::OFF_W'(7)));
        send_request(make_req(vpa_pkg::OP_COMPACT, '0, '0, '0));
        send_request(make_req(vpa_pkg::OP_XLATE, 16'h101, '0, vpa_pkg::OFF_W'(3)));
    endtask

    task automatic random_phase(int count, int idle, int stall);
        sender_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) send_request(random_request());
    endtask

    initial begin
        best_fit = 1'b0;
        mem_bytes = 1048576;
        clear_tables();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of every field, each operation, and the no-fit, duplicate and no-pid codes.
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'h0000, '0, '0));
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'hFFFF, vpa_pkg::SIZE_W'(21'h1FFFFF), '0));
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'hFFFF, vpa_pkg::SIZE_W'(1048576), '0));
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'hFFFF, vpa_pkg::SIZE_W'(1), '0));
        send_request(make_req(vpa_pkg::OP_XLATE, 16'hFFFF, '0, vpa_pkg::OFF_W'(20'hFFFFF)));
        send_request(make_req(vpa_pkg::OP_FREE, 16'h0000, '0, '0));
        send_request(make_req(vpa_pkg::OP_FREE, 16'hFFFF, '0, '0));
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'h0001, vpa_pkg::SIZE_W'(1048576), '0));
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'h0002, vpa_pkg::SIZE_W'(1), '0));
        send_request(make_req(vpa_pkg::OP_XLATE, 16'h0001, '0, vpa_pkg::OFF_W'(20'hFFFFF)));
        send_request(make_req(vpa_pkg::OP_COMPACT, '1, '1, '1));
        send_request(make_req(vpa_pkg::OP_FREE, 16'h0001, '0, '0));
        send_request(make_req(vpa_pkg::OP_COMPACT, '0, '0, '0));
        drain();
        fragment_phase();
        drain();

        cfg_write(vpa_pkg::CFG_FIT_POLICY, vpa_pkg::CFG_W'(1));
        fragment_phase();
        random_phase(200, 0, 0);
        drain();

        // Tiny memories, including zero and a single byte.
        cfg_write(vpa_pkg::CFG_MEMORY_SIZE, '0);
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'h7, vpa_pkg::SIZE_W'(1), '0));
        send_request(make_req(vpa_pkg::OP_COMPACT, '0, '0, '0));
        drain();
        cfg_write(vpa_pkg::CFG_MEMORY_SIZE, vpa_pkg::CFG_W'(1));
        send_request(make_req(vpa_pkg::OP_ALLOC, 16'h7, vpa_pkg::SIZE_W'(1), '0));
        send_request(make_req(vpa_pkg::OP_XLATE, 16'h7, '0, vpa_pkg::OFF_W'(0)));
        send_request(make_req(vpa_pkg::OP_COMPACT, '0, '0, '0));
        drain();
        cfg_write(vpa_pkg::CFG_MEMORY_SIZE, '1);
        cfg_write(vpa_pkg::CFG_FIT_POLICY, '0);
        random_phase(450, 56, 0);
        drain();

        cfg_write(vpa_pkg::CFG_MEMORY_SIZE, vpa_pkg::CFG_W'(300000));
        cfg_write(vpa_pkg::CFG_FIT_POLICY, vpa_pkg::CFG_W'(1));
        random_phase(450, 0, 56);

        // Back-pressure: hold the receiver off while requests keep coming.
        sender_idle_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                repeat (600) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++) send_request(random_request());
        join
        drain();

        cfg_write(vpa_pkg::CFG_MEMORY_SIZE, vpa_pkg::CFG_W'(1048576));
        cfg_write(vpa_pkg::CFG_FIT_POLICY, '0);
        random_phase(420, 36, 36);
        drain();
        cfg_write(vpa_pkg::CFG_MEMORY_SIZE, vpa_pkg::CFG_W'(4096));
        cfg_write(vpa_pkg::CFG_FIT_POLICY, vpa_pkg::CFG_W'(1));
        random_phase(400, 0, 0);

        drain();
        $display("covered %0d requests over fit policies and memory sizes 0 to 2M,",
                 sent);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire
